>>> design/hfdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfdec_pkg
// shared types and constants of the huffman tree walk decoder
// ----------------------------------------------------------------------------
package hfdec_pkg;

	localparam int IDX_BITS  = 9;
	localparam int SYM_BITS  = 8;
	localparam int BYTE_BITS = 8;
	localparam int CNT_BITS  = 4;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef logic [IDX_BITS-1:0] idx_t;
	typedef logic [SYM_BITS-1:0] sym_t;

	// one node table entry
	typedef struct packed {
		logic is_leaf;
		sym_t symbol;
		idx_t left;
		idx_t right;
	} node_t;

	// input word
	typedef struct packed {
		logic                 operation;
		idx_t                 node_index;
		logic                 node_is_leaf;
		sym_t                 node_symbol;
		idx_t                 left_child;
		idx_t                 right_child;
		logic [BYTE_BITS-1:0] code_byte;
		logic [CNT_BITS-1:0]  valid_bits;
		logic                 stream_start;
	} in_word_t;

	// output word
	typedef struct packed {
		sym_t symbol;
		logic last_of_byte;
	} out_word_t;

endpackage
`default_nettype wire

>>> design/hfdec_node_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfdec_node_ram
// node table: one write port, one registered read port, out-of-range reads
// return an all-zero entry and out-of-range writes are dropped
// ----------------------------------------------------------------------------
module hfdec_node_ram #(
	parameter int NODE_COUNT = 512
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  hfdec_pkg::idx_t     wr_addr,
	input  hfdec_pkg::node_t    wr_data,
	input  wire                 rd_en,
	input  hfdec_pkg::idx_t     rd_addr,
	output hfdec_pkg::node_t    rd_data
);

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int IW = hfdec_pkg::IDX_BITS;

	hfdec_pkg::node_t mem [NODE_COUNT];
	hfdec_pkg::node_t rd_q;
	logic             oob_q;
	logic             wr_in_range;
	logic             rd_in_range;

	assign wr_in_range = {1'b0, wr_addr} < (IW+1)'(NODE_COUNT);
	assign rd_in_range = {1'b0, rd_addr} < (IW+1)'(NODE_COUNT);

	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem[wr_addr[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oob_q <= 1'b0;
		end else if (rd_en) begin
			oob_q <= !rd_in_range;
		end
	end

	assign rd_data = oob_q ? hfdec_pkg::node_t'('0) : rd_q;

endmodule
`default_nettype wire

>>> design/huffman_tree_walk_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top
// huffman decoder that walks a node table held in a synchronous ram
// ----------------------------------------------------------------------------
// Write-node words load the node table. A decode word is accepted in
// S_IDLE; S_ROOT, S_LOADR and S_LOADW then fetch the root entry and the
// current walk entry; S_RUN takes one valid code bit per cycle unless a
// stalled output holds it, then one more step that resolves the fetch of
// the last bit; S_FLUSH hands the final symbol to the output register.
// The one-bit-per-cycle rate is set by the loop from the node ram's
// registered read data through the child select back to the ram read
// address. Each emitted symbol leaves through a single output register; one
// symbol is held back until the next one appears or the byte ends, so that
// last_of_byte can be marked on it. A root register write also moves the
// walk back to the root. Table entries that were never written read as
// unknown data.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_top #(
	parameter int NODE_COUNT = 512
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// input channel
	input  wire                   in_valid,
	output logic                  in_stall,
	input  hfdec_pkg::in_word_t   in_data,
	// output channel
	output logic                  out_valid,
	input  wire                   out_stall,
	output hfdec_pkg::out_word_t  out_data,
	// root index register
	input  wire                   cfg_we,
	input  hfdec_pkg::idx_t       cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROOT,
		S_LOADR,
		S_LOADW,
		S_RUN,
		S_FLUSH
	} state_t;

	state_t                          state_q;
	hfdec_pkg::idx_t                 root_q;
	hfdec_pkg::idx_t                 walk_q;
	hfdec_pkg::idx_t                 next_q;
	hfdec_pkg::node_t                root_e_q;
	hfdec_pkg::node_t                cur_q;
	logic [hfdec_pkg::BYTE_BITS-1:0] byte_q;
	logic [hfdec_pkg::CNT_BITS-1:0]  cnt_q;
	logic                            inflight_q;
	logic                            pend_v_q;
	hfdec_pkg::sym_t                 pend_q;

	// ram port
	logic                            ram_wr_en;
	hfdec_pkg::node_t                ram_wr_data;
	logic                            ram_rd_en;
	hfdec_pkg::idx_t                 ram_rd_addr;
	hfdec_pkg::node_t                ram_rd_data;

	// walk step
	logic                            in_acc;
	logic                            slot_free;
	logic                            emit;
	hfdec_pkg::sym_t                 emit_sym;
	logic                            hold;
	hfdec_pkg::idx_t                 res_walk;
	hfdec_pkg::node_t                res_cur;
	logic                            issue;
	hfdec_pkg::idx_t                 next_idx;
	logic [hfdec_pkg::CNT_BITS-1:0]  sat_cnt;
	logic                            out_load;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid || !out_stall;

	// saturate the bit count at one byte
	assign sat_cnt = (in_data.valid_bits > hfdec_pkg::CNT_BITS'(hfdec_pkg::BYTE_BITS)) ?
		hfdec_pkg::CNT_BITS'(hfdec_pkg::BYTE_BITS) : in_data.valid_bits;

	assign ram_wr_en   = in_acc && (in_data.operation == hfdec_pkg::OP_WRITE);
	assign ram_wr_data = '{is_leaf: in_data.node_is_leaf, symbol: in_data.node_symbol,
		left: in_data.left_child, right: in_data.right_child};

	always_comb begin
		res_walk = walk_q;
		res_cur  = cur_q;
		emit     = 1'b0;
		emit_sym = root_e_q.symbol;
		// resolve the node fetched for the previous bit
		if (inflight_q) begin
			if (ram_rd_data.is_leaf) begin
				emit     = 1'b1;
				emit_sym = ram_rd_data.symbol;
				res_walk = root_q;
				res_cur  = root_e_q;
			end else begin
				res_walk = next_q;
				res_cur  = ram_rd_data;
			end
		end
		// leaf root: every bit gives the root symbol, no fetch
		if ((cnt_q != '0) && root_e_q.is_leaf) begin
			emit     = 1'b1;
			emit_sym = root_e_q.symbol;
			res_walk = root_q;
		end
		// a new symbol pushes the held one out, which needs the output slot
		hold     = (state_q == S_RUN) && emit && pend_v_q && !slot_free;
		next_idx = byte_q[hfdec_pkg::BYTE_BITS-1] ? res_cur.right : res_cur.left;
		issue    = (state_q == S_RUN) && !hold && (cnt_q != '0) && !root_e_q.is_leaf;
		// the output register takes a word this cycle
		out_load = ((state_q == S_RUN) && !hold && emit && pend_v_q)
			|| ((state_q == S_FLUSH) && pend_v_q && slot_free);

		ram_rd_en   = 1'b0;
		ram_rd_addr = next_idx;
		case (state_q)
			S_ROOT: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = root_q;
			end
			S_LOADR: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = walk_q;
			end
			S_RUN: begin
				ram_rd_en   = issue;
				ram_rd_addr = next_idx;
			end
			default: begin
				ram_rd_en   = 1'b0;
			end
		endcase
	end

	hfdec_node_ram #(
		.NODE_COUNT (NODE_COUNT)
	) u_node_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ram_wr_en),
		.wr_addr (in_data.node_index),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			root_q     <= '0;
			walk_q     <= '0;
			next_q     <= '0;
			root_e_q   <= '0;
			cur_q      <= '0;
			byte_q     <= '0;
			cnt_q      <= '0;
			inflight_q <= 1'b0;
			pend_v_q   <= 1'b0;
			pend_q     <= '0;
			out_valid  <= 1'b0;
			out_data   <= '0;
		end else begin
			// output register drains unless it takes a new word
			if (out_valid && !out_stall && !out_load) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc && (in_data.operation == hfdec_pkg::OP_DECODE)) begin
						byte_q  <= in_data.code_byte;
						cnt_q   <= sat_cnt;
						if (in_data.stream_start) begin
							walk_q <= root_q;
						end
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					state_q <= S_LOADR;
				end
				S_LOADR: begin
					root_e_q <= ram_rd_data;
					state_q  <= S_LOADW;
				end
				S_LOADW: begin
					cur_q      <= ram_rd_data;
					inflight_q <= 1'b0;
					state_q    <= S_RUN;
				end
				S_RUN: begin
					if (!hold) begin
						walk_q     <= res_walk;
						cur_q      <= res_cur;
						inflight_q <= issue;
						if (emit) begin
							pend_q   <= emit_sym;
							pend_v_q <= 1'b1;
							if (pend_v_q) begin
								out_valid <= 1'b1;
								out_data  <= '{symbol: pend_q, last_of_byte: 1'b0};
							end
						end
						if (cnt_q != '0) begin
							cnt_q  <= cnt_q - 1'b1;
							byte_q <= {byte_q[hfdec_pkg::BYTE_BITS-2:0], 1'b0};
							if (issue) begin
								next_q <= next_idx;
							end
						end else begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					// final symbol of the byte carries the last mark
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (slot_free) begin
						out_valid <= 1'b1;
						out_data  <= '{symbol: pend_q, last_of_byte: 1'b1};
						pend_v_q  <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// root register write also resets the walk
			if (cfg_we) begin
				root_q <= cfg_wdata;
				walk_q <= cfg_wdata;
			end
		end
	end

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// regression for huffman_tree_walk_decoder_top
// ----------------------------------------------------------------------------
// Node trees are planted in the decoder's table with write words. Streams of
// compressed bytes are then decoded against them. A behavioral copy of the
// decoder runs while the words are generated and queues the symbols that
// each byte must produce. A clocked driver sends the words with random gaps.
// A clocked monitor takes the symbols with random stall runs and checks each
// one against the oldest queued symbol. The root register is changed only
// between phases, once the decoder has drained.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NODES        = 512;
	localparam int DRAIN_CYCLES = 30;   // covers the longest decode, a saturated byte, plus output handoff
	localparam int HOLD_CYCLES  = 400;  // one long receiver hold-off
	localparam int HOLD_AT_WORD = 150;  // symbol count that triggers it
	localparam int PHASE_WORDS  = 85;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	hfdec_pkg::in_word_t  in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	hfdec_pkg::out_word_t out_data;
	logic                 cfg_we    = 1'b0;
	hfdec_pkg::idx_t      cfg_wdata = '0;

	huffman_tree_walk_decoder_top #(
		.NODE_COUNT(NODES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// decoder shadow state: node table, which entries hold data, root, walk
	// ------------------------------------------------------------------------
	hfdec_pkg::node_t     node_mem [NODES];
	bit                   node_loaded [NODES];
	hfdec_pkg::idx_t      root_sel  = '0;
	hfdec_pkg::idx_t      walk_node = '0;

	hfdec_pkg::out_word_t expected_symbols [$];
	hfdec_pkg::in_word_t  pending_words [$];

	int words_queued;
	int words_taken;
	int symbols_seen;
	int mismatches;
	int send_gap;
	int recv_gap;
	int hold_left;

	// ------------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------------

	// counts above eight saturate
	function automatic int bits_used(logic [hfdec_pkg::CNT_BITS-1:0] vb);
		return (vb > hfdec_pkg::BYTE_BITS) ? hfdec_pkg::BYTE_BITS : int'(vb);
	endfunction

	// mostly short gaps, a few long ones, none at all inside a calm stretch
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	// every bit of every field random, the caller then sets what matters
	function automatic hfdec_pkg::in_word_t random_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(hfdec_pkg::in_word_t)-1:0];
	endfunction

	function automatic hfdec_pkg::in_word_t node_word(hfdec_pkg::idx_t at, logic leaf,
			hfdec_pkg::sym_t sym, hfdec_pkg::idx_t lft, hfdec_pkg::idx_t rgt);
		hfdec_pkg::in_word_t w;
		w = random_word();
		w.operation    = hfdec_pkg::OP_WRITE;
		w.node_index   = at;
		w.node_is_leaf = leaf;
		w.node_symbol  = sym;
		w.left_child   = lft;
		w.right_child  = rgt;
		return w;
	endfunction

	function automatic hfdec_pkg::in_word_t decode_word(
			logic [hfdec_pkg::BYTE_BITS-1:0] code,
			logic [hfdec_pkg::CNT_BITS-1:0] vb, bit start);
		hfdec_pkg::in_word_t w;
		w = random_word();
		w.operation    = hfdec_pkg::OP_DECODE;
		w.code_byte    = code;
		w.valid_bits   = vb;
		w.stream_start = start;
		return w;
	endfunction

	// true when decoding this byte touches only table entries that hold data
	function automatic bit walk_stays_loaded(hfdec_pkg::in_word_t w);
		hfdec_pkg::idx_t pos;
		hfdec_pkg::idx_t nxt;
		if (!node_loaded[root_sel])
			return 1'b0;
		pos = w.stream_start ? root_sel : walk_node;
		if (!node_loaded[pos])
			return 1'b0;
		if (node_mem[root_sel].is_leaf)
			return 1'b1;
		for (int b = 0; b < bits_used(w.valid_bits); b++) begin
			nxt = w.code_byte[hfdec_pkg::BYTE_BITS-1-b] ? node_mem[pos].right
				: node_mem[pos].left;
			if (!node_loaded[nxt])
				return 1'b0;
			pos = node_mem[nxt].is_leaf ? root_sel : nxt;
		end
		return 1'b1;
	endfunction

	// advance the shadow decoder by one word and queue the symbols it yields
	task automatic predict_symbols(hfdec_pkg::in_word_t w);
		hfdec_pkg::node_t     root_e;
		hfdec_pkg::node_t     step_e;
		hfdec_pkg::idx_t      nxt;
		hfdec_pkg::out_word_t held;
		bit                   have_held;
		bit                   emit;
		hfdec_pkg::sym_t      sym;
		if (w.operation == hfdec_pkg::OP_WRITE) begin
			node_mem[w.node_index]    = {w.node_is_leaf, w.node_symbol, w.left_child,
				w.right_child};
			node_loaded[w.node_index] = 1'b1;
			return;
		end
		root_e    = node_mem[root_sel];
		held      = '0;
		have_held = 1'b0;
		nxt       = '0;
		if (w.stream_start)
			walk_node = root_sel;
		for (int b = 0; b < bits_used(w.valid_bits); b++) begin
			if (root_e.is_leaf) begin
				// leaf root: every bit yields the root symbol
				emit = 1'b1;
				sym  = root_e.symbol;
			end else begin
				nxt    = w.code_byte[hfdec_pkg::BYTE_BITS-1-b] ? node_mem[walk_node].right
					: node_mem[walk_node].left;
				step_e = node_mem[nxt];
				emit   = step_e.is_leaf;
				sym    = step_e.symbol;
			end
			if (emit) begin
				// hold one back so the last of the byte can be marked
				if (have_held)
					expected_symbols = {expected_symbols, held};
				held      = {sym, 1'b0};
				have_held = 1'b1;
				walk_node = root_sel;
			end else
				walk_node = nxt;
		end
		if (have_held) begin
			held.last_of_byte = 1'b1;
			expected_symbols = {expected_symbols, held};
		end
	endtask

	task automatic offer_word(hfdec_pkg::in_word_t w);
		predict_symbols(w);
		pending_words = {pending_words, w};
		words_queued++;
	endtask

	// restart the walk if the byte would wander into never written entries,
	// drop the byte if even that does not help
	task automatic offer_decode(hfdec_pkg::in_word_t w);
		if (!walk_stays_loaded(w))
			w.stream_start = 1'b1;
		if (walk_stays_loaded(w))
			offer_word(w);
	endtask

	// random full binary tree rooted at the current root, grown by splitting leaves
	task automatic plant_tree(int leaves);
		hfdec_pkg::idx_t slot [64];
		int              lo [64];
		int              hi [64];
		bit              inner [64];
		bit              taken [NODES];
		int              count;
		int              k;
		hfdec_pkg::idx_t pick;
		hfdec_pkg::idx_t lft;
		hfdec_pkg::idx_t rgt;
		slot[0]        = root_sel;
		taken[root_sel] = 1'b1;
		count          = 1;
		repeat (leaves - 1) begin
			do
				k = $urandom_range(0, count - 1);
			while (inner[k]);
			for (int c = 0; c < 2; c++) begin
				do
					pick = hfdec_pkg::idx_t'($urandom_range(0, NODES - 1));
				while (taken[pick]);
				taken[pick] = 1'b1;
				slot[count] = pick;
				if (c == 0)
					lo[k] = count;
				else
					hi[k] = count;
				count++;
			end
			inner[k] = 1'b1;
		end
		// children of a leaf are don't-care, so they get random links
		for (int n = count - 1; n >= 0; n--) begin
			lft = inner[n] ? slot[lo[n]] : hfdec_pkg::idx_t'($urandom);
			rgt = inner[n] ? slot[hi[n]] : hfdec_pkg::idx_t'($urandom);
			offer_word(node_word(slot[n], !inner[n], hfdec_pkg::sym_t'($urandom), lft, rgt));
		end
	endtask

	// one code stream: full bytes, a short final byte, some noise on top
	task automatic play_stream(int bytes);
		int                  r;
		int                  vb;
		hfdec_pkg::in_word_t w;
		for (int i = 0; i < bytes; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				// stray node write at a random entry
				w           = random_word();
				w.operation = hfdec_pkg::OP_WRITE;
				offer_word(w);
			end
			vb = (i == bytes - 1) ? $urandom_range(1, 8) : hfdec_pkg::BYTE_BITS;
			if (r >= 90)
				vb = $urandom_range(0, 15);
			offer_decode(decode_word(hfdec_pkg::BYTE_BITS'($urandom),
				hfdec_pkg::CNT_BITS'(vb), (i == 0) || (r >= 85 && r < 90)));
		end
	endtask

	task automatic random_phase(int words);
		int target;
		int r;
		int leaves;
		target = words_queued + words;
		while (words_queued < target) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				leaves = 1;
			else if (r < 85)
				leaves = $urandom_range(2, 10);
			else
				leaves = $urandom_range(11, 32);
			plant_tree(leaves);
			play_stream($urandom_range(4, 20));
		end
	endtask

	function automatic bit decoder_drained();
		return pending_words.size() == 0 && words_taken == words_queued
			&& expected_symbols.size() == 0;
	endfunction

	// root write only while the decoder is idle; it also moves the walk
	task automatic retarget_root(hfdec_pkg::idx_t v);
		while (!decoder_drained())
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		root_sel  = v;
		walk_node = v;
	endtask

	// ------------------------------------------------------------------------
	// driver: one word at a time from the pending queue, gap after each word
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				words_taken++;
			// a stalled word stays put
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (pending_words.size() != 0) begin
					in_data  <= pending_words.pop_front();
					in_valid <= 1'b1;
					send_gap = pick_gap(((words_taken / 40) % 3) == 1);
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: check each symbol, then pick the stall for the next cycle
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : symbol_check
		hfdec_pkg::out_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_symbols.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected symbol %h last %b", $realtime,
							out_data.symbol, out_data.last_of_byte);
				end else begin
					want = expected_symbols.pop_front();
					if (out_data.symbol !== want.symbol
							|| out_data.last_of_byte !== want.last_of_byte) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: symbol %h last %b, expected symbol %h last %b",
								$realtime, out_data.symbol, out_data.last_of_byte,
								want.symbol, want.last_of_byte);
					end
				end
				symbols_seen++;
				recv_gap = pick_gap(((symbols_seen / 40) % 3) == 1);
				// long hold-off so the decoder backs up into its input
				if (symbols_seen == HOLD_AT_WORD)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		hfdec_pkg::in_word_t w;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: root at 0, codes 0 -> 00, 10 -> ff, 11 -> a5
		retarget_root(hfdec_pkg::idx_t'(0));
		offer_word(node_word(9'd0, 1'b0, 8'h3c, 9'd1, 9'd511));
		offer_word(node_word(9'd1, 1'b1, 8'h00, 9'd0, 9'd0));
		offer_word(node_word(9'd511, 1'b0, 8'hc3, 9'd2, 9'd3));
		offer_word(node_word(9'd2, 1'b1, 8'hff, 9'd511, 9'd511));
		offer_word(node_word(9'd3, 1'b1, 8'ha5, 9'd0, 9'd511));
		offer_decode(decode_word(8'h00, 4'd8, 1'b1));   // eight symbols in one byte
		offer_decode(decode_word(8'hff, 4'd8, 1'b0));
		offer_decode(decode_word(8'ha5, 4'd8, 1'b0));   // ends in the middle of a code
		offer_decode(decode_word(8'h7f, 4'd15, 1'b0));  // count saturates, walk carried over
		offer_decode(decode_word(8'h80, 4'd0, 1'b0));   // no bits at all
		offer_decode(decode_word(8'h80, 4'd1, 1'b1));   // restart, no symbol in the byte
		w              = node_word(9'd4, 1'b1, 8'h5a, 9'd0, 9'd0);
		w.stream_start = 1'b1;                           // ignored on a node write
		offer_word(w);
		offer_decode(decode_word(8'h40, 4'd2, 1'b0));
		// root turned into a leaf while the walk sits below it
		offer_decode(decode_word(8'h80, 4'd1, 1'b1));
		offer_word(node_word(9'd0, 1'b1, 8'h5a, 9'd511, 9'd1));
		offer_decode(decode_word(8'hc3, 4'd3, 1'b0));
		offer_word(node_word(9'd0, 1'b0, 8'h3c, 9'd1, 9'd511));
		offer_decode(decode_word(8'hff, 4'd9, 1'b1));

		// root at the top entry, walk moved there by the register write
		retarget_root(hfdec_pkg::idx_t'(NODES - 1));
		offer_decode(decode_word(8'h5a, 4'd8, 1'b0));
		offer_word(node_word(9'd511, 1'b1, 8'h96, 9'd511, 9'd0));
		offer_decode(decode_word(8'h00, 4'd4, 1'b0));

		// random phases, each behind a root change
		retarget_root(hfdec_pkg::idx_t'($urandom_range(1, NODES - 2)));
		random_phase(PHASE_WORDS);
		retarget_root(hfdec_pkg::idx_t'(0));
		random_phase(PHASE_WORDS);
		retarget_root(hfdec_pkg::idx_t'($urandom_range(0, NODES - 1)));
		random_phase(PHASE_WORDS);
		retarget_root(hfdec_pkg::idx_t'($urandom_range(0, NODES - 1)));
		random_phase(PHASE_WORDS);

		while (!decoder_drained())
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_symbols.size() == 0)
			$display("huffman_tree_walk_decoder_top regression: pass");
		else
			$display("huffman_tree_walk_decoder_top regression: fail");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#50_000_000;
		$display("huffman_tree_walk_decoder_top regression: fail");
		$finish;
	end

endmodule
